// ----- sv/sst_pkg.sv -----
package sst_pkg;

  localparam int ACT_W     = 3;
  localparam int KEY_W     = 10;
  localparam int POS_W     = 8;
  localparam int CNT_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 10;

  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 3'd2;
  localparam logic [ACT_W-1:0] ACT_GET    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_KEY     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DENSE_LIMIT = 1'd1;

  localparam logic [KEY_W-1:0] MAX_KEY_RST     = 10'd1023;
  localparam logic [CNT_W-1:0] DENSE_LIMIT_RST = 9'd256;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ,
    ST_DECIDE,
    ST_DEL
  } state_t;

  typedef struct packed {
    logic sweep;        // zero one sparse entry
    logic accept;       // take request, issue first reads
    logic dense_reread; // dense read at the sparse entry
    logic finish;       // commit action unless a delete hit, load result
    logic last_read;    // read the last dense entry
    logic del_commit;   // move last entry into the hole, load result
  } cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic del_hit;
    logic out_free;
  } sts_t;

endpackage

// ----- sv/sst_req_if.sv -----
interface sst_req_if;
  logic                      valid;
  logic                      ready;
  logic [sst_pkg::ACT_W-1:0] action;
  logic [sst_pkg::KEY_W-1:0] key;
  logic [sst_pkg::POS_W-1:0] position;

  modport source (output valid, action, key, position, input ready);
  modport sink   (input valid, action, key, position, output ready);
endinterface

// ----- sv/sst_rsp_if.sv -----
interface sst_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      ok;
  logic [sst_pkg::POS_W-1:0] found_position;
  logic [sst_pkg::KEY_W-1:0] found_key;
  logic [sst_pkg::CNT_W-1:0] member_count;

  modport source (output valid, ok, found_position, found_key, member_count, input ready);
  modport sink   (input valid, ok, found_position, found_key, member_count, output ready);
endinterface

// ----- sv/sst_ram.sv -----
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/sst_ctrl.sv -----
module sst_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  sst_pkg::sts_t sts,
  output logic          req_ready,
  output sst_pkg::cmd_t cmd
);

  sst_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sst_pkg::ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    case (state)
      sst_pkg::ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_done) begin
          state_next = sst_pkg::ST_IDLE;
        end
      end
      sst_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = sst_pkg::ST_READ;
        end
      end
      sst_pkg::ST_READ: begin
        cmd.dense_reread = 1'b1;
        state_next       = sst_pkg::ST_DECIDE;
      end
      sst_pkg::ST_DECIDE: begin
        if (sts.del_hit) begin
          cmd.last_read = 1'b1;
          state_next    = sst_pkg::ST_DEL;
        end else if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = sst_pkg::ST_IDLE;
        end
      end
      sst_pkg::ST_DEL: begin
        if (sts.out_free) begin
          cmd.del_commit = 1'b1;
          state_next     = sst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sst_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/sst_dp.sv -----
module sst_dp #(
  parameter int KEY_SPACE   = 1024,
  parameter int DENSE_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sst_pkg::CFG_W-1:0]     cfg_data,
  input  logic [sst_pkg::ACT_W-1:0]     req_action,
  input  logic [sst_pkg::KEY_W-1:0]     req_key,
  input  logic [sst_pkg::POS_W-1:0]     req_position,
  input  logic                          rsp_ready,
  input  sst_pkg::cmd_t                 cmd,
  output sst_pkg::sts_t                 sts,
  output logic                          rsp_valid,
  output logic                          rsp_ok,
  output logic [sst_pkg::POS_W-1:0]     rsp_found_position,
  output logic [sst_pkg::KEY_W-1:0]     rsp_found_key,
  output logic [sst_pkg::CNT_W-1:0]     rsp_member_count
);

  localparam int KAW = $clog2(KEY_SPACE);
  localparam int DAW = $clog2(DENSE_DEPTH);

  logic [sst_pkg::ACT_W-1:0] action_r;
  logic [sst_pkg::KEY_W-1:0] key_r;
  logic [sst_pkg::POS_W-1:0] pos_r;
  logic [sst_pkg::KEY_W-1:0] max_key;
  logic [sst_pkg::CNT_W-1:0] dense_limit;
  logic [sst_pkg::CNT_W-1:0] members, members_next;
  logic [KAW-1:0]            sweep_addr;

  logic                      sp_we, sp_re;
  logic [KAW-1:0]            sp_waddr, sp_raddr;
  logic [sst_pkg::CNT_W-1:0] sp_wdata, sp_rdata;
  logic                      dn_we, dn_re;
  logic [DAW-1:0]            dn_waddr, dn_raddr;
  logic [sst_pkg::KEY_W-1:0] dn_wdata, dn_rdata;

  logic                      key_ok, hit, load_out;
  logic [sst_pkg::CNT_W-1:0] cap;
  logic                      ok_next;
  logic [sst_pkg::POS_W-1:0] fpos_next;
  logic [sst_pkg::KEY_W-1:0] fkey_next;

  sst_ram #(.WIDTH(sst_pkg::CNT_W), .DEPTH(KEY_SPACE)) u_sparse (
    .clk   (clk),
    .we    (sp_we),
    .waddr (sp_waddr),
    .wdata (sp_wdata),
    .re    (sp_re),
    .raddr (sp_raddr),
    .rdata (sp_rdata)
  );

  sst_ram #(.WIDTH(sst_pkg::KEY_W), .DEPTH(DENSE_DEPTH)) u_dense (
    .clk   (clk),
    .we    (dn_we),
    .waddr (dn_waddr),
    .wdata (dn_wdata),
    .re    (dn_re),
    .raddr (dn_raddr),
    .rdata (dn_rdata)
  );

  assign key_ok = (key_r <= max_key) && (32'(key_r) < KEY_SPACE);
  // sparse entry is only trusted when it points at a live dense slot holding the key
  assign hit    = key_ok && (sp_rdata < members) && (32'(sp_rdata) < DENSE_DEPTH) &&
                  (dn_rdata == key_r);
  assign cap    = (32'(dense_limit) > DENSE_DEPTH) ? sst_pkg::CNT_W'(DENSE_DEPTH)
                                                   : dense_limit;

  assign sts.sweep_done = (sweep_addr == KAW'(KEY_SPACE - 1));
  assign sts.del_hit    = (action_r == sst_pkg::ACT_DELETE) && hit;
  assign sts.out_free   = !rsp_valid || rsp_ready;

  assign sp_re    = cmd.accept;
  assign sp_raddr = KAW'(req_key);

  assign dn_re    = cmd.accept || cmd.last_read ||
                    (cmd.dense_reread && (action_r != sst_pkg::ACT_GET));
  assign dn_raddr = cmd.accept    ? DAW'(req_position) :
                    cmd.last_read ? DAW'(members - 1'b1) : DAW'(sp_rdata);

  assign load_out = cmd.finish || cmd.del_commit;

  always_comb begin
    sp_we        = 1'b0;
    sp_waddr     = sweep_addr;
    sp_wdata     = '0;
    dn_we        = 1'b0;
    dn_waddr     = DAW'(members);
    dn_wdata     = key_r;
    members_next = members;
    ok_next      = 1'b0;
    fpos_next    = '0;
    fkey_next    = '0;
    if (cmd.sweep) begin
      sp_we = 1'b1;
    end else if (cmd.del_commit) begin
      // dn_rdata holds the last member, sp_rdata the hole
      dn_we        = 1'b1;
      dn_waddr     = DAW'(sp_rdata);
      dn_wdata     = dn_rdata;
      sp_we        = 32'(dn_rdata) < KEY_SPACE;
      sp_waddr     = KAW'(dn_rdata);
      sp_wdata     = sp_rdata;
      members_next = members - 1'b1;
      ok_next      = 1'b1;
    end else if (cmd.finish) begin
      case (action_r)
        sst_pkg::ACT_INSERT: begin
          if (key_ok && (members < cap) && !hit) begin
            sp_we        = 1'b1;
            sp_waddr     = KAW'(key_r);
            sp_wdata     = members;
            dn_we        = 1'b1;
            members_next = members + 1'b1;
            ok_next      = 1'b1;
          end
        end
        sst_pkg::ACT_SEARCH: begin
          ok_next   = hit;
          fpos_next = hit ? sst_pkg::POS_W'(sp_rdata) : '0;
        end
        sst_pkg::ACT_GET: begin
          if ((sst_pkg::CNT_W'(pos_r) < members) && (32'(pos_r) < DENSE_DEPTH)) begin
            ok_next   = 1'b1;
            fkey_next = dn_rdata;
          end
        end
        sst_pkg::ACT_CLEAR: begin
          members_next = '0;
          ok_next      = 1'b1;
        end
        default: begin
          ok_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_key     <= sst_pkg::MAX_KEY_RST;
      dense_limit <= sst_pkg::DENSE_LIMIT_RST;
      members     <= '0;
      sweep_addr  <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sst_pkg::CFG_MAX_KEY:     max_key     <= cfg_data;
          sst_pkg::CFG_DENSE_LIMIT: dense_limit <= sst_pkg::CNT_W'(cfg_data);
          default: ;
        endcase
      end
      if (cmd.sweep) begin
        sweep_addr <= sweep_addr + 1'b1;
      end
      members <= members_next;
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      action_r <= req_action;
      key_r    <= req_key;
      pos_r    <= req_position;
    end
    if (load_out) begin
      rsp_ok             <= ok_next;
      rsp_found_position <= fpos_next;
      rsp_found_key      <= fkey_next;
      rsp_member_count   <= members_next;
    end
  end

endmodule

// ----- sv/sparse_set_table_top.sv -----
// Sparse set of keys: a sparse index memory (key -> dense slot) and a dense
// key memory, plus a member count.
// req channel: one transaction per action (insert, delete, search, get,
// clear) with key and position. rsp channel: exactly one transaction per
// request with ok, found_position, found_key and the member count after
// the action.
// Config: cfg_we with cfg_index 0 writes max_key, index 1 writes
// dense_limit. Write only while no request is in flight.
// Response path: after the request transaction come a sparse read, then the
// dependent dense read, each a registered memory read, before rsp.valid
// rises; a delete that removes a member needs one more dense read for the
// last member.
// A new request is taken only after the previous one has loaded its result,
// but the next request is taken while the previous result still waits in
// the output register.
// Reset: members and config return to defaults, then the sparse memory is
// zeroed, one entry a cycle, before req.ready rises.
// Stall: while rsp.ready is low the result holds and a following request
// waits at its decision step (at its delete step if it removes a member).
module sparse_set_table_top #(
  parameter int KEY_SPACE   = 1024,
  parameter int DENSE_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sst_pkg::CFG_W-1:0]     cfg_data,
  sst_req_if.sink                       req,
  sst_rsp_if.source                     rsp
);

  sst_pkg::cmd_t cmd;
  sst_pkg::sts_t sts;

  sst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .sts       (sts),
    .req_ready (req.ready),
    .cmd       (cmd)
  );

  sst_dp #(.KEY_SPACE(KEY_SPACE), .DENSE_DEPTH(DENSE_DEPTH)) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .req_action         (req.action),
    .req_key            (req.key),
    .req_position       (req.position),
    .rsp_ready          (rsp.ready),
    .cmd                (cmd),
    .sts                (sts),
    .rsp_valid          (rsp.valid),
    .rsp_ok             (rsp.ok),
    .rsp_found_position (rsp.found_position),
    .rsp_found_key      (rsp.found_key),
    .rsp_member_count   (rsp.member_count)
  );

endmodule
